@@ rtl/core/aio_pkg.sv @@
package aio_pkg;

    // Access kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Port numbers
    localparam logic [7:0] PORT_ID         = 8'd0;
    localparam logic [7:0] PORT_BUTTONS    = 8'd1;
    localparam logic [7:0] PORT_DIP_AMOUNT = 8'd2;
    localparam logic [7:0] PORT_SHIFT_SND1 = 8'd3;
    localparam logic [7:0] PORT_SHIFT_DATA = 8'd4;
    localparam logic [7:0] PORT_SND2       = 8'd5;

    // Fixed values
    localparam logic [7:0] PORT0_VALUE = 8'h74;
    localparam logic [6:0] UFO_LIMIT   = 7'd100;

    typedef struct packed {
        logic       operation;
        logic [7:0] port;
        logic [7:0] write_data;
        logic [5:0] buttons;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic [8:0] sound_triggers;
    } t_rsp;

endpackage

@@ rtl/core/aio_port_unit.sv @@
module aio_port_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_req_accept,
    input  aio_pkg::t_req i_req,
    output aio_pkg::t_rsp o_rsp
);
    import aio_pkg::*;

    logic [7:0]  r_dip;
    logic [2:0]  r_shift_amount;
    logic [7:0]  r_shift_low;
    logic [7:0]  r_shift_high;
    logic [2:0]  r_port3_last;
    logic [4:0]  r_port5_last;
    logic [6:0]  r_ufo_count;

    logic [7:0]  n_shift_low;
    logic [7:0]  n_shift_high;
    logic [2:0]  n_shift_amount;
    logic [2:0]  n_port3_last;
    logic [4:0]  n_port5_last;
    logic [6:0]  n_ufo_count;

    logic [15:0] shifted;
    logic [2:0]  snd1_bits;
    logic [4:0]  snd2_bits;
    logic [7:0]  rd_data;
    logic [8:0]  trig;

    // Window of the shift pair selected by the amount
    assign shifted   = {r_shift_high, r_shift_low} << r_shift_amount;
    assign snd1_bits = i_req.write_data[3:1];
    assign snd2_bits = i_req.write_data[4:0];

    // Decode the request into a response and the next state
    always_comb begin
        rd_data        = '0;
        trig           = '0;
        n_shift_amount = r_shift_amount;
        n_shift_low    = r_shift_low;
        n_shift_high   = r_shift_high;
        n_port3_last   = r_port3_last;
        n_port5_last   = r_port5_last;
        n_ufo_count    = r_ufo_count;
        if (i_req.operation == OP_READ) begin
            unique case (i_req.port)
                PORT_ID:         rd_data = PORT0_VALUE;
                PORT_BUTTONS:    rd_data = {1'b0, i_req.buttons[5:3], 1'b0, i_req.buttons[2:0]};
                PORT_DIP_AMOUNT: rd_data = r_dip;
                PORT_SHIFT_SND1: rd_data = shifted[15:8];
                default:         rd_data = '0;
            endcase
        end else begin
            unique case (i_req.port)
                PORT_DIP_AMOUNT: n_shift_amount = i_req.write_data[2:0];
                PORT_SHIFT_SND1: begin
                    if (i_req.write_data[0]) begin
                        if (r_ufo_count == UFO_LIMIT) begin
                            trig[0]     = 1'b1;
                            n_ufo_count = '0;
                        end else begin
                            n_ufo_count = r_ufo_count + 7'd1;
                        end
                    end
                    trig[3:1]    = snd1_bits & ~r_port3_last;
                    n_port3_last = snd1_bits;
                end
                PORT_SHIFT_DATA: begin
                    n_shift_low  = r_shift_high;
                    n_shift_high = i_req.write_data;
                end
                PORT_SND2: begin
                    trig[8:4]    = snd2_bits & ~r_port5_last;
                    n_port5_last = snd2_bits;
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.read_data      = rd_data;
    assign o_rsp.sound_triggers = trig;

    // Hold port state; advance it on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip          <= '0;
            r_shift_amount <= '0;
            r_shift_low    <= '0;
            r_shift_high   <= '0;
            r_port3_last   <= '0;
            r_port5_last   <= '0;
            r_ufo_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dip <= i_cfg_data;
            end
            if (i_req_accept) begin
                r_shift_amount <= n_shift_amount;
                r_shift_low    <= n_shift_low;
                r_shift_high   <= n_shift_high;
                r_port3_last   <= n_port3_last;
                r_port5_last   <= n_port5_last;
                r_ufo_count    <= n_ufo_count;
            end
        end
    end

`ifndef SYNTH
    a_ufo_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ufo_count <= UFO_LIMIT)
        else $error("ufo counter passed its limit");

    a_read_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_accept && i_req.operation == OP_READ) |=>
            ($stable(r_shift_low) && $stable(r_shift_high) && $stable(r_ufo_count)
             && $stable(r_port3_last) && $stable(r_port5_last)))
        else $error("read request changed port state");

    a_ufo_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_accept && trig[0]) |=> (r_ufo_count == '0))
        else $error("ufo trigger without counter clear");
`endif

endmodule

@@ rtl/core/arcade_io_ports_with_shifter_core.sv @@
// Channel   Direction  Handshake        Payload
// in        input      valid / stall    t_req: operation, port, write_data, buttons
// out       output     valid / stall    t_rsp: read_data, sound_triggers
// cfg       input      valid / ready    dip_switches byte
//
// One request per cycle unless stalled; its response is registered in result or skid.
// Decode, shifter and edge detection sit between the request and the result register.
// Synchronous active-low reset clears port state, dip switches and valid flags.
// A skid register takes one response while the output stalls; input stall is registered.
// Configuration writes are taken every cycle.
module arcade_io_ports_with_shifter_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  aio_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output aio_pkg::t_rsp o_out_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_data
);
    import aio_pkg::*;

    logic  r_out_valid;
    t_rsp  r_out_rsp;
    logic  r_skid_valid;
    t_rsp  r_skid_rsp;
    logic  in_accept;
    logic  out_free;
    t_rsp  rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    aio_port_unit u_port_unit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_req_accept (in_accept),
        .i_req        (i_in_req),
        .o_rsp        (rsp)
    );

    // Load the result register, drain the skid first, park a response when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_rsp <= r_skid_valid ? r_skid_rsp : rsp;
        end else if (in_accept) begin
            r_skid_rsp <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a response while the output is empty");

    a_accept_yields_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted request produced no response");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid filled without an output stall");
`endif

endmodule
